// ----- design/cce_pkg.sv -----
// shared constants and types for the configurable crc engine
`timescale 1ns / 1ps

package cce_pkg;

    // widest crc register supported by default
    localparam int MAX_WIDTH_DEF = 64;

    // field widths
    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int CRC_OUT_W   = 64;
    localparam int CRC_WIDTH_W = 7;

    // register indexes on the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CRC_WIDTH      = 3'd0,
        CFG_GENERATOR_POLY = 3'd1,
        CFG_INITIAL_VALUE  = 3'd2,
        CFG_FINAL_XOR      = 3'd3,
        CFG_REFLECT_INPUT  = 3'd4,
        CFG_REFLECT_OUTPUT = 3'd5
    } cce_cfg_index_t;

    // register values after reset (crc-32)
    localparam logic [CRC_WIDTH_W-1:0] RST_CRC_WIDTH      = 7'd32;
    localparam logic [CFG_DATA_W-1:0]  RST_GENERATOR_POLY = 64'h0000_0000_04C1_1DB7;
    localparam logic [CFG_DATA_W-1:0]  RST_INITIAL_VALUE  = 64'h0000_0000_FFFF_FFFF;
    localparam logic [CFG_DATA_W-1:0]  RST_FINAL_XOR      = 64'h0000_0000_FFFF_FFFF;
    localparam logic                   RST_REFLECT_INPUT  = 1'b1;
    localparam logic                   RST_REFLECT_OUTPUT = 1'b1;

endpackage

// ----- design/cce_byte_step.sv -----
// eight-bit crc update network for one message byte
`timescale 1ns / 1ps

module cce_byte_step
    import cce_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic [MAX_WIDTH-1:0]         rem_in,
    input  logic [BYTE_W-1:0]            data_byte,
    input  logic                         byte_valid,
    input  logic                         reflect,
    input  logic [$clog2(MAX_WIDTH)-1:0] shamt,
    input  logic [MAX_WIDTH-1:0]         mask,
    input  logic [MAX_WIDTH-1:0]         poly_aligned,
    input  logic [MAX_WIDTH-1:0]         poly_reflected,
    output logic [MAX_WIDTH-1:0]         rem_out
);

    localparam int MW = MAX_WIDTH;

    logic [MW-1:0] norm_acc;
    logic [MW-1:0] refl_acc;

    // normal form runs left-aligned so the top bit is always bit MW-1
    always_comb begin
        norm_acc = (rem_in << shamt) ^ (MW'(data_byte) << (MW - BYTE_W));
        for (int k = 0; k < BYTE_W; k++) begin
            if (norm_acc[MW-1]) begin
                norm_acc = (norm_acc << 1) ^ poly_aligned;
            end else begin
                norm_acc = norm_acc << 1;
            end
        end
    end

    // reflected form runs right-aligned, lsb first
    always_comb begin
        refl_acc = (rem_in & mask) ^ MW'(data_byte);
        for (int k = 0; k < BYTE_W; k++) begin
            if (refl_acc[0]) begin
                refl_acc = (refl_acc >> 1) ^ poly_reflected;
            end else begin
                refl_acc = refl_acc >> 1;
            end
        end
    end

    // pick the result, or just trim to width when no byte comes in
    always_comb begin
        if (!byte_valid) begin
            rem_out = rem_in & mask;
        end else if (reflect) begin
            rem_out = refl_acc;
        end else begin
            rem_out = norm_acc >> shamt;
        end
    end

endmodule

// ----- design/configurable_crc_engine.sv -----
// top level of the configurable crc engine
// an item is taken into the input register, and a last item then moves on through
// fin_reg and the output register to m_crc_value; throughput: one item per cycle
// while s_ready is high; the remainder loop through the byte xor network sets the rate
// a result stalled on m_ready holds the input side only once three results are queued
// reset: synchronous active-low aresetn clears all valids and the open message and
// loads the crc-32 register defaults
`timescale 1ns / 1ps

module configurable_crc_engine
    import cce_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // message bytes
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [BYTE_W-1:0]      s_data_byte,
    input  logic                   s_byte_valid,
    input  logic                   s_is_last,
    // finished crcs
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [CRC_OUT_W-1:0]   m_crc_value
);

    localparam int MW = MAX_WIDTH;
    localparam int SW = $clog2(MAX_WIDTH);
    localparam logic [CRC_WIDTH_W-1:0] MW_W = CRC_WIDTH_W'(MAX_WIDTH);
    localparam logic [CRC_WIDTH_W-1:0] MIN_W = CRC_WIDTH_W'(BYTE_W);

    function automatic logic [MW-1:0] rev_bits(input logic [MW-1:0] v);
        logic [MW-1:0] r;
        for (int i = 0; i < MW; i++) begin
            r[i] = v[MW-1-i];
        end
        return r;
    endfunction

    // configuration registers
    logic [CRC_WIDTH_W-1:0] crc_width_reg;
    logic [CFG_DATA_W-1:0]  generator_poly_reg;
    logic [CFG_DATA_W-1:0]  initial_value_reg;
    logic [CFG_DATA_W-1:0]  final_xor_reg;
    logic                   reflect_input_reg;
    logic                   reflect_output_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_width_reg      <= RST_CRC_WIDTH;
            generator_poly_reg <= RST_GENERATOR_POLY;
            initial_value_reg  <= RST_INITIAL_VALUE;
            final_xor_reg      <= RST_FINAL_XOR;
            reflect_input_reg  <= RST_REFLECT_INPUT;
            reflect_output_reg <= RST_REFLECT_OUTPUT;
        end else if (cfg_valid && cfg_ready) begin
            case (cce_cfg_index_t'(cfg_index))
                CFG_CRC_WIDTH:      crc_width_reg      <= cfg_data[CRC_WIDTH_W-1:0];
                CFG_GENERATOR_POLY: generator_poly_reg <= cfg_data;
                CFG_INITIAL_VALUE:  initial_value_reg  <= cfg_data;
                CFG_FINAL_XOR:      final_xor_reg      <= cfg_data;
                CFG_REFLECT_INPUT:  reflect_input_reg  <= cfg_data[0];
                CFG_REFLECT_OUTPUT: reflect_output_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // settings derived from the registers, registered behind them
    logic [CRC_WIDTH_W-1:0] width_eff;
    logic [CRC_WIDTH_W-1:0] shamt_wide;
    logic [SW-1:0]          shamt_next;
    logic [MW-1:0]          mask_next;
    logic [MW-1:0]          poly_al_next;
    logic [MW-1:0]          init_al_next;
    logic [MW-1:0]          init_load_next;

    logic [SW-1:0] shamt_reg;
    logic [MW-1:0] mask_reg;
    logic [MW-1:0] poly_al_reg;
    logic [MW-1:0] poly_rf_reg;
    logic [MW-1:0] init_load_reg;
    logic [MW-1:0] fxor_reg;
    logic          reflect_reg;
    logic          flip_reg;

    always_comb begin
        if (crc_width_reg < MIN_W) begin
            width_eff = MIN_W;
        end else if (crc_width_reg > MW_W) begin
            width_eff = MW_W;
        end else begin
            width_eff = crc_width_reg;
        end
        shamt_wide     = MW_W - width_eff;
        shamt_next     = shamt_wide[SW-1:0];
        mask_next      = {MW{1'b1}} >> shamt_next;
        poly_al_next   = (generator_poly_reg[MW-1:0] & mask_next) << shamt_next;
        init_al_next   = (initial_value_reg[MW-1:0] & mask_next) << shamt_next;
        init_load_next = reflect_input_reg ? rev_bits(init_al_next)
                                           : (initial_value_reg[MW-1:0] & mask_next);
    end

    always_ff @(posedge aclk) begin
        shamt_reg     <= shamt_next;
        mask_reg      <= mask_next;
        poly_al_reg   <= poly_al_next;
        poly_rf_reg   <= rev_bits(poly_al_next);
        init_load_reg <= init_load_next;
        fxor_reg      <= final_xor_reg[MW-1:0] & mask_next;
        reflect_reg   <= reflect_input_reg;
        flip_reg      <= reflect_input_reg ^ reflect_output_reg;
    end

    // handshake through the three stages
    logic s1_valid_reg;
    logic fin_valid_reg;
    logic m_valid_reg;
    logic s1_last_reg;
    logic out_free;
    logic fin_advance;
    logic fin_free;
    logic s1_advance;

    assign out_free    = !m_valid_reg || m_ready;
    assign fin_advance = fin_valid_reg && out_free;
    assign fin_free    = !fin_valid_reg || fin_advance;
    assign s1_advance  = s1_valid_reg && (!s1_last_reg || fin_free);
    assign s_ready     = !s1_valid_reg || s1_advance;

    // input register
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_byte_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_byte_reg       <= s_data_byte;
            s1_byte_valid_reg <= s_byte_valid;
            s1_last_reg       <= s_is_last;
        end
    end

    // running remainder and message state
    logic [MW-1:0] rem_reg;
    logic          in_msg_reg;
    logic [MW-1:0] rem_start;
    logic [MW-1:0] rem_next;

    assign rem_start = in_msg_reg ? rem_reg : init_load_reg;

    cce_byte_step #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_byte_step (
        .rem_in        (rem_start),
        .data_byte     (s1_byte_reg),
        .byte_valid    (s1_byte_valid_reg),
        .reflect       (reflect_reg),
        .shamt         (shamt_reg),
        .mask          (mask_reg),
        .poly_aligned  (poly_al_reg),
        .poly_reflected(poly_rf_reg),
        .rem_out       (rem_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_msg_reg <= 1'b0;
        end else if (s1_advance) begin
            in_msg_reg <= !s1_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            rem_reg <= rem_next;
        end
    end

    // raw remainder of a finished message
    logic [MW-1:0] fin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (fin_free) begin
            fin_valid_reg <= s1_advance && s1_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && s1_last_reg && fin_free) begin
            fin_reg <= rem_next;
        end
    end

    // finalize: optional mirror over the width, then xor and trim
    logic [MW-1:0]        fin_mirror;
    logic [MW-1:0]        fin_value;
    logic [CRC_OUT_W-1:0] m_crc_value_next;
    logic [CRC_OUT_W-1:0] m_crc_value_reg;

    always_comb begin
        fin_mirror       = rev_bits(fin_reg) >> shamt_reg;
        fin_value        = ((flip_reg ? fin_mirror : fin_reg) ^ fxor_reg) & mask_reg;
        m_crc_value_next = CRC_OUT_W'(fin_value);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_advance) begin
            m_crc_value_reg <= m_crc_value_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_crc_value = m_crc_value_reg;

endmodule

// ----- design/cce_checker.sv -----
// port-level checks for the configurable crc engine, bound to the top level
`timescale 1ns / 1ps

module cce_checker
    import cce_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 s_is_last,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [CRC_OUT_W-1:0] m_crc_value
);

    // count of message ends taken in but not yet delivered
    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       end_in;
    logic       crc_out;

    assign end_in  = s_valid && s_ready && s_is_last;
    assign crc_out = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg;
        if (end_in && !crc_out) begin
            pending_next = pending_reg + 3'd1;
        end else if (!end_in && crc_out) begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 3'd0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // a stalled crc holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_crc_value))
        else $error("crc changed or dropped while stalled");

    // no crc without a message end behind it
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 3'd0)
        else $error("crc item with no message end taken in");

    // at most three finished messages in flight
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 3'd3)
        else $error("more message ends in flight than stages");

    // input holds off only when every stage holds a finished message
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> pending_reg == 3'd3 && m_valid && !m_ready)
        else $error("input held off while a stage is free");

endmodule

bind configurable_crc_engine cce_checker u_cce_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_is_last  (s_is_last),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_crc_value(m_crc_value)
);

// ----- sim/crc_checker.sv -----
// checker that tracks the crc engine registers, predicts each crc and compares results
`timescale 1ns / 1ps

module crc_checker
    import cce_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [BYTE_W-1:0]      s_data_byte,
    input  logic                   s_byte_valid,
    input  logic                   s_is_last,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [CRC_OUT_W-1:0]   m_crc_value,
    output int                     error_count,
    output int                     crcs_pending,
    output int                     crcs_checked
);

    // shadow copy of the register file
    logic [CRC_WIDTH_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0]  poly_reg;
    logic [CFG_DATA_W-1:0]  init_reg;
    logic [CFG_DATA_W-1:0]  xor_reg;
    logic                   refin_reg;
    logic                   refout_reg;

    // running message state
    logic [CRC_OUT_W-1:0] remainder;
    logic                 msg_open;
    logic [CRC_OUT_W-1:0] expected_crcs[$];
    int                   errors = 0;
    int                   checked = 0;

    // effective register width, clamped to 8..MAX_WIDTH
    function automatic int crc_span(input logic [CRC_WIDTH_W-1:0] w);
        if (w < 8) return 8;
        if (w > MAX_WIDTH) return MAX_WIDTH;
        return int'(w);
    endfunction

    function automatic logic [63:0] span_mask(input int w);
        return (w >= 64) ? {64{1'b1}} : ((64'd1 << w) - 64'd1);
    endfunction

    // reverse the low w bits
    function automatic logic [63:0] bit_mirror(input logic [63:0] v, input int w);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < w; i++) r[w-1-i] = v[i];
        return r;
    endfunction

    // one byte through the shift register, bit by bit
    function automatic logic [63:0] absorb_byte(input logic [63:0] rem, input logic [7:0] b,
                                                input int w);
        logic [63:0] m;
        logic [63:0] p;
        logic [63:0] r;
        logic [63:0] top;
        m = span_mask(w);
        p = poly_reg & m;
        r = rem & m;
        if (refin_reg) begin
            p = bit_mirror(p, w);
            r = r ^ {56'd0, b};
            for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ p) : (r >> 1);
        end else begin
            top = 64'd1 << (w - 1);
            r = r ^ ({56'd0, b} << (w - 8));
            for (int k = 0; k < 8; k++) r = ((r & top) != 0) ? ((r << 1) ^ p) : (r << 1);
        end
        return r & m;
    endfunction

    // fold one accepted item into the message, queue the crc on the last one
    task automatic fold_item(input logic [7:0] b, input logic bv, input logic last);
        int          w;
        logic [63:0] m;
        logic [63:0] r;
        w = crc_span(width_reg);
        m = span_mask(w);
        if (!msg_open) begin
            remainder = refin_reg ? bit_mirror(init_reg & m, w) : (init_reg & m);
            msg_open  = 1'b1;
        end
        if (bv) remainder = absorb_byte(remainder, b, w);
        if (last) begin
            r = remainder & m;
            if (refin_reg != refout_reg) r = bit_mirror(r, w);
            expected_crcs.push_back((r ^ xor_reg) & m);
            msg_open = 1'b0;
        end
    endtask

    // watch all three channels
    always @(posedge aclk) begin
        logic [CRC_OUT_W-1:0] want;
        if (!aresetn) begin
            width_reg  = RST_CRC_WIDTH;
            poly_reg   = RST_GENERATOR_POLY;
            init_reg   = RST_INITIAL_VALUE;
            xor_reg    = RST_FINAL_XOR;
            refin_reg  = RST_REFLECT_INPUT;
            refout_reg = RST_REFLECT_OUTPUT;
            remainder  = '0;
            msg_open   = 1'b0;
            expected_crcs.delete();
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CRC_WIDTH:      width_reg  = cfg_data[CRC_WIDTH_W-1:0];
                    CFG_GENERATOR_POLY: poly_reg   = cfg_data;
                    CFG_INITIAL_VALUE:  init_reg   = cfg_data;
                    CFG_FINAL_XOR:      xor_reg    = cfg_data;
                    CFG_REFLECT_INPUT:  refin_reg  = cfg_data[0];
                    CFG_REFLECT_OUTPUT: refout_reg = cfg_data[0];
                    default: ;
                endcase
            end
            // message items
            if (s_valid && s_ready) fold_item(s_data_byte, s_byte_valid, s_is_last);
            // finished crcs
            if (m_valid && m_ready) begin
                if (expected_crcs.size() == 0) begin
                    $error("crc_value: expected none, actual %h", m_crc_value);
                    errors++;
                end else begin
                    want = expected_crcs.pop_front();
                    checked++;
                    if (m_crc_value !== want) begin
                        $error("crc_value: expected %h, actual %h", want, m_crc_value);
                        errors++;
                    end
                end
            end
        end
        error_count  <= errors;
        crcs_pending <= expected_crcs.size();
        crcs_checked <= checked;
    end

endmodule

// ----- sim/configurable_crc_engine_tb.sv -----
// testbench top for the configurable crc engine: stimulus, idling and verdict
`timescale 1ns / 1ps

module configurable_crc_engine_tb;
    import cce_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 11;
    localparam int ITEM_TARGET    = 900;
    localparam int IDLE_PCT       = 38;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 6;
    localparam int STALL_LIMIT    = 5000;

    // indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    // well-known generator polynomials
    localparam logic [63:0] POLY_CRC32  = 64'h04C1_1DB7;
    localparam logic [63:0] POLY_CRC32C = 64'h1EDC_6F41;
    localparam logic [63:0] POLY_CRC16  = 64'h8005;
    localparam logic [63:0] POLY_CCITT  = 64'h1021;
    localparam logic [63:0] POLY_CRC8   = 64'h07;
    localparam logic [63:0] ALL_ONES    = {64{1'b1}};

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    logic [BYTE_W-1:0]      s_data_byte;
    logic                   s_byte_valid;
    logic                   s_is_last;
    logic                   m_valid;
    logic                   m_ready;
    logic [CRC_OUT_W-1:0]   m_crc_value;

    int error_count;
    int crcs_pending;
    int crcs_checked;

    bit tx_idle_on;
    bit rx_idle_on;
    bit rx_hold_req;
    int items_sent;
    int reg_writes;

    always #(CLK_HALF) aclk = ~aclk;

    configurable_crc_engine uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_byte_valid (s_byte_valid),
        .s_is_last    (s_is_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_crc_value  (m_crc_value)
    );

    crc_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_byte_valid (s_byte_valid),
        .s_is_last    (s_is_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_crc_value  (m_crc_value),
        .error_count  (error_count),
        .crcs_pending (crcs_pending),
        .crcs_checked (crcs_checked)
    );

    // offer one item, with random gaps ahead of it
    task automatic send_item(input logic [7:0] b, input logic bv, input logic last);
        while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= b;
        s_byte_valid <= bv;
        s_is_last    <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (bv || last) items_sent++;
    endtask

    // sender pauses until every crc has come back and the pipe is empty
    task automatic wait_crcs_done();
        s_valid <= 1'b0;
        do @(posedge aclk); while (crcs_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data,
                             input bit close);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (close) cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic set_config(input logic [63:0] w, input logic [63:0] poly,
                              input logic [63:0] init, input logic [63:0] xo,
                              input logic [63:0] rin, input logic [63:0] rout);
        write_reg(CFG_CRC_WIDTH, w, 1'b0);
        write_reg(CFG_GENERATOR_POLY, poly, 1'b0);
        write_reg(CFG_INITIAL_VALUE, init, 1'b0);
        write_reg(CFG_FINAL_XOR, xo, 1'b0);
        write_reg(CFG_REFLECT_INPUT, rin, 1'b0);
        write_reg(CFG_REFLECT_OUTPUT, rout, 1'b1);
    endtask

    // random setting, biased toward the width extremes and stock polynomials
    task automatic apply_random_config();
        logic [6:0]  w;
        logic [63:0] wdata;
        logic [63:0] poly;
        logic [63:0] init;
        logic [63:0] xo;
        case ($urandom_range(5))
            0: w = 7'd8;
            1: w = 7'd64;
            2: w = 7'($urandom_range(7));
            3: w = 7'($urandom_range(127, 65));
            default: w = 7'($urandom_range(64, 8));
        endcase
        wdata = {$urandom, $urandom};
        wdata[6:0] = w;
        case ($urandom_range(6))
            0: poly = POLY_CRC32;
            1: poly = POLY_CRC32C;
            2: poly = POLY_CRC16;
            3: poly = POLY_CCITT;
            4: poly = POLY_CRC8;
            default: poly = {$urandom, $urandom};
        endcase
        case ($urandom_range(3))
            0: init = '0;
            1: init = ALL_ONES;
            default: init = {$urandom, $urandom};
        endcase
        case ($urandom_range(3))
            0: xo = '0;
            1: xo = ALL_ONES;
            default: xo = {$urandom, $urandom};
        endcase
        set_config(wdata, poly, init, xo, {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    // bytes with stray idle items, closed by a last item unless left open
    task automatic send_message(input int len, input bit close);
        repeat (len) begin
            if ($urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, 1'b0);
        end
        if (close) send_item(8'($urandom), 1'($urandom_range(1)), 1'b1);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= !(rx_idle_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // watchdog on cycles with no accepted item on any channel
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        wait (aresetn);
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("configurable_crc_engine_tb failed");
        $finish;
    end

    // stimulus
    initial begin
        int phase;
        int len;
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_data_byte  = '0;
        s_byte_valid = 1'b0;
        s_is_last    = 1'b0;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        rx_hold_req  = 1'b0;
        items_sent   = 0;
        reg_writes   = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty message under the crc-32 defaults
        send_item(8'h00, 1'b0, 1'b1);
        // short message with an idle item in the middle
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b1);
        wait_crcs_done();

        // idle item opens a message, then width and polynomial change under it
        send_item(8'hFF, 1'b0, 1'b0);
        wait_crcs_done();
        write_reg(CFG_CRC_WIDTH, 64'd16, 1'b0);
        write_reg(CFG_GENERATOR_POLY, POLY_CCITT, 1'b0);
        write_reg(CFG_SPARE_LO, ALL_ONES, 1'b0);
        write_reg(CFG_SPARE_HI, ALL_ONES, 1'b1);
        send_item(8'hA5, 1'b1, 1'b1);
        wait_crcs_done();

        // width below range acts as 8, wide poly and init get masked
        set_config(64'hFFFF_FFFF_FFFF_FF80, 64'hFFFF_FFFF_FFFF_FF07, 64'hA5A5_A5A5_A5A5_A5C3,
                   ALL_ONES, 64'd0, 64'd0);
        send_item(8'h31, 1'b1, 1'b0);
        send_item(8'h32, 1'b1, 1'b1);
        wait_crcs_done();

        // width above range acts as 64, plain input, reflected output
        set_config(64'h7F, 64'h42F0_E1EB_A9EA_3693, ALL_ONES, 64'd0, 64'd0, 64'd1);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b1);
        wait_crcs_done();

        // full 64-bit register, reflected input, plain output, last item carries no byte
        set_config(64'd64, 64'h42F0_E1EB_A9EA_3693, 64'd0, ALL_ONES, 64'd1, 64'd0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        wait_crcs_done();

        // crc-8, no reflection
        set_config(64'd8, POLY_CRC8, 64'd0, 64'd0, 64'd0, 64'd0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);

        // random phases, each under a fresh setting
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            wait_crcs_done();
            apply_random_config();
            tx_idle_on = (phase != 2);
            rx_idle_on = (phase != 2);
            // long receiver hold-off while single-byte messages keep coming
            if (phase == 4) begin
                rx_hold_req = 1'b1;
                repeat (24) send_item(8'($urandom), 1'b1, 1'b1);
            end
            repeat ($urandom_range(14, 8)) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(12);
                send_message(len, 1'b1);
            end
            // sometimes leave a message open across the next register writes
            if ($urandom_range(2) == 0) send_message($urandom_range(1, 6), 1'b0);
            phase++;
        end
        wait_crcs_done();

        $display("ran %0d message items to %0d checked crcs over %0d register writes",
                 items_sent, crcs_checked, reg_writes);
        $display("widths 8 to 64 and out of range, both reflections, writes inside messages");
        if (error_count == 0 && crcs_pending == 0) begin
            $display("configurable_crc_engine_tb passed");
        end else begin
            $display("configurable_crc_engine_tb failed");
        end
        $finish;
    end

endmodule
